[hw/rtl/assert_macros.svh]
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bsc_pkg.sv]
package bsc_pkg;

    localparam int RegIdxW  = 3;
    localparam int PaddrW   = 5;

    // register indexes
    localparam logic [RegIdxW-1:0] REG_AC1   = 3'd0;
    localparam logic [RegIdxW-1:0] REG_AC2   = 3'd1;
    localparam logic [RegIdxW-1:0] REG_AC3   = 3'd2;
    localparam logic [RegIdxW-1:0] REG_AC4   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_AC5   = 3'd4;
    localparam logic [RegIdxW-1:0] REG_AC6   = 3'd5;
    localparam logic [RegIdxW-1:0] REG_B1B2  = 3'd6;
    localparam logic [RegIdxW-1:0] REG_MCMD  = 3'd7;

    // typical calibration words
    localparam logic [15:0] RST_AC1  = 16'd408;
    localparam logic [15:0] RST_AC2  = 16'hFFB8;
    localparam logic [15:0] RST_AC3  = 16'hC7D1;
    localparam logic [15:0] RST_AC4  = 16'd32741;
    localparam logic [15:0] RST_AC5  = 16'd32757;
    localparam logic [15:0] RST_AC6  = 16'd23153;
    localparam logic [31:0] RST_B1B2 = 32'd405667844;
    localparam logic [31:0] RST_MCMD = 32'd3724290868;

    localparam logic [31:0] K_B6_OFS = 32'd4000;
    localparam logic [31:0] K_B4_OFS = 32'd32768;
    localparam logic [31:0] K_B7_MUL = 32'd50000;
    localparam logic [31:0] K_SIGN   = 32'h8000_0000;
    localparam logic [31:0] K_MG     = 32'd3038;
    localparam logic [31:0] K_MH     = 32'hFFFF_E343;
    localparam logic [31:0] K_MI     = 32'd3791;

    // datapath operations
    localparam int OpW = 5;
    localparam logic [OpW-1:0] OP_T_DIFF = 5'd0;
    localparam logic [OpW-1:0] OP_T_X1   = 5'd1;
    localparam logic [OpW-1:0] OP_T_DEN  = 5'd2;
    localparam logic [OpW-1:0] OP_T_CHK  = 5'd3;
    localparam logic [OpW-1:0] OP_T_B5   = 5'd4;
    localparam logic [OpW-1:0] OP_T_VAL  = 5'd5;
    localparam logic [OpW-1:0] OP_P_B6   = 5'd6;
    localparam logic [OpW-1:0] OP_P_SQ   = 5'd7;
    localparam logic [OpW-1:0] OP_P_X1A  = 5'd8;
    localparam logic [OpW-1:0] OP_P_X2A  = 5'd9;
    localparam logic [OpW-1:0] OP_P_X3A  = 5'd10;
    localparam logic [OpW-1:0] OP_P_B3   = 5'd11;
    localparam logic [OpW-1:0] OP_P_X1B  = 5'd12;
    localparam logic [OpW-1:0] OP_P_X2B  = 5'd13;
    localparam logic [OpW-1:0] OP_P_X3B  = 5'd14;
    localparam logic [OpW-1:0] OP_P_T    = 5'd15;
    localparam logic [OpW-1:0] OP_P_B4   = 5'd16;
    localparam logic [OpW-1:0] OP_P_DIFF = 5'd17;
    localparam logic [OpW-1:0] OP_P_B7   = 5'd18;
    localparam logic [OpW-1:0] OP_P_CHK  = 5'd19;
    localparam logic [OpW-1:0] OP_P_P    = 5'd20;
    localparam logic [OpW-1:0] OP_P_F1   = 5'd21;
    localparam logic [OpW-1:0] OP_P_F2   = 5'd22;
    localparam logic [OpW-1:0] OP_P_F3   = 5'd23;
    localparam logic [OpW-1:0] OP_P_F4   = 5'd24;
    localparam logic [OpW-1:0] OP_P_F5   = 5'd25;
    localparam logic [OpW-1:0] OP_P_VAL  = 5'd26;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
    } cfg_t;

    typedef struct packed {
        logic           load;
        logic           exec;
        logic [OpW-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic div_busy;
    } status_t;

endpackage

[hw/rtl/bsc_in_if.sv]
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] raw_value;

    modport source (output valid, output action, output raw_value, input ready);
    modport sink   (input valid, input action, input raw_value, output ready);
endinterface

[hw/rtl/bsc_out_if.sv]
interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;
    logic               div_error;

    modport source (output valid, output kind, output value, output div_error, input ready);
    modport sink   (input valid, input kind, input value, input div_error, output ready);
endinterface

[hw/rtl/bsc_regs.sv]
module bsc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bsc_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output bsc_pkg::cfg_t             cfg
);
    import bsc_pkg::*;

    cfg_t                cfg_reg;
    logic                wr_en;
    logic [RegIdxW-1:0]  idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[PaddrW-1:2];
    assign cfg   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ac1   <= RST_AC1;
            cfg_reg.ac2   <= RST_AC2;
            cfg_reg.ac3   <= RST_AC3;
            cfg_reg.ac4   <= RST_AC4;
            cfg_reg.ac5   <= RST_AC5;
            cfg_reg.ac6   <= RST_AC6;
            cfg_reg.b1_b2 <= RST_B1B2;
            cfg_reg.mc_md <= RST_MCMD;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_AC1:  cfg_reg.ac1   <= pwdata[15:0];
                REG_AC2:  cfg_reg.ac2   <= pwdata[15:0];
                REG_AC3:  cfg_reg.ac3   <= pwdata[15:0];
                REG_AC4:  cfg_reg.ac4   <= pwdata[15:0];
                REG_AC5:  cfg_reg.ac5   <= pwdata[15:0];
                REG_AC6:  cfg_reg.ac6   <= pwdata[15:0];
                REG_B1B2: cfg_reg.b1_b2 <= pwdata;
                REG_MCMD: cfg_reg.mc_md <= pwdata;
                default:  cfg_reg.ac1   <= cfg_reg.ac1;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_AC1:  prdata = {16'd0, cfg_reg.ac1};
            REG_AC2:  prdata = {16'd0, cfg_reg.ac2};
            REG_AC3:  prdata = {16'd0, cfg_reg.ac3};
            REG_AC4:  prdata = {16'd0, cfg_reg.ac4};
            REG_AC5:  prdata = {16'd0, cfg_reg.ac5};
            REG_AC6:  prdata = {16'd0, cfg_reg.ac6};
            REG_B1B2: prdata = cfg_reg.b1_b2;
            REG_MCMD: prdata = cfg_reg.mc_md;
            default:  prdata = 32'd0;
        endcase
    end

endmodule

[hw/rtl/bsc_ctrl.sv]
module bsc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_action,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bsc_pkg::status_t status,
    output bsc_pkg::cmd_t    cmd
);
    import bsc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]     state_reg, state_next;
    logic [OpW-1:0] op_reg, op_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd.load = (state_reg == S_IDLE) && in_valid;
        cmd.exec = (state_reg == S_RUN);
        cmd.op   = op_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RUN;
                    op_next    = in_action ? OP_P_B6 : OP_T_DIFF;
                end
            end
            S_RUN:
            begin
                op_next = op_reg + 1'b1;
                if (op_reg == OP_T_VAL || op_reg == OP_P_VAL)
                begin
                    state_next = S_OUT;
                end
                else if (op_reg == OP_T_CHK || op_reg == OP_P_CHK)
                begin
                    state_next = status.zero ? S_OUT : S_DIV;
                end
            end
            S_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_RUN;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_T_DIFF;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

[hw/rtl/bsc_dp.sv]
module bsc_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  bsc_pkg::cfg_t    cfg,
    input  bsc_pkg::cmd_t    cmd,
    input  logic             in_action,
    input  logic [15:0]      in_raw,
    output bsc_pkg::status_t status,
    output logic             res_kind,
    output logic [31:0]      res_value,
    output logic             res_err
);
    import bsc_pkg::*;

    logic [31:0] ac1_s, ac2_s, ac3_s, ac4_u, ac5_u, ac6_u, b1_s, b2_s, mc_s, md_s;

    logic        kind_reg;
    logic [15:0] raw_reg;
    logic [31:0] b5_reg;
    logic [31:0] x1_reg, x2_reg, x3_reg, b6_reg, sq_reg, b3_reg, b4_reg, p_reg;
    logic [31:0] value_reg;
    logic        err_reg;
    logic        pflag_reg;

    logic [31:0]        mul_a, mul_b, prod;
    logic signed [31:0] prod_s;
    logic [31:0]        raw_u, sum_a, sum_b;

    // serial restoring divider
    logic [31:0] div_rem_reg, div_quo_reg, div_den_reg;
    logic [4:0]  div_cnt_reg;
    logic        div_busy_reg, div_neg_reg;
    logic [32:0] trial;
    logic [33:0] diff;
    logic [31:0] div_q;
    logic        div_load;
    logic [31:0] div_num, div_dvs;
    logic        div_sgn;

    assign ac1_s = {{16{cfg.ac1[15]}}, cfg.ac1};
    assign ac2_s = {{16{cfg.ac2[15]}}, cfg.ac2};
    assign ac3_s = {{16{cfg.ac3[15]}}, cfg.ac3};
    assign ac4_u = {16'd0, cfg.ac4};
    assign ac5_u = {16'd0, cfg.ac5};
    assign ac6_u = {16'd0, cfg.ac6};
    assign b1_s  = {{16{cfg.b1_b2[31]}}, cfg.b1_b2[31:16]};
    assign b2_s  = {{16{cfg.b1_b2[15]}}, cfg.b1_b2[15:0]};
    assign mc_s  = {{16{cfg.mc_md[31]}}, cfg.mc_md[31:16]};
    assign md_s  = {{16{cfg.mc_md[15]}}, cfg.mc_md[15:0]};
    assign raw_u = {16'd0, raw_reg};

    always_comb
    begin
        case (cmd.op)
            OP_T_X1:  begin mul_a = p_reg;  mul_b = ac5_u;    end
            OP_P_SQ:  begin mul_a = b6_reg; mul_b = b6_reg;   end
            OP_P_X1A: begin mul_a = sq_reg; mul_b = b2_s;     end
            OP_P_X2A: begin mul_a = ac2_s;  mul_b = b6_reg;   end
            OP_P_X1B: begin mul_a = ac3_s;  mul_b = b6_reg;   end
            OP_P_X2B: begin mul_a = b1_s;   mul_b = sq_reg;   end
            OP_P_B4:  begin mul_a = ac4_u;  mul_b = x3_reg;   end
            OP_P_B7:  begin mul_a = p_reg;  mul_b = K_B7_MUL; end
            OP_P_F2:  begin mul_a = x1_reg; mul_b = x1_reg;   end
            OP_P_F3:  begin mul_a = x1_reg; mul_b = K_MG;     end
            OP_P_F4:  begin mul_a = p_reg;  mul_b = K_MH;     end
            default:  begin mul_a = 32'd0;  mul_b = 32'd0;    end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_s = prod;

    // shared adder operands for the multi-term sums
    always_comb
    begin
        case (cmd.op)
            OP_P_B3: begin sum_a = {ac1_s[29:0], 2'b00}; sum_b = x3_reg + 32'd2; end
            OP_P_X3B: begin sum_a = x1_reg; sum_b = x2_reg + 32'd2; end
            OP_P_F5: begin sum_a = x1_reg; sum_b = x2_reg + K_MI; end
            default: begin sum_a = x1_reg; sum_b = x2_reg; end
        endcase
    end

    assign status.zero     = (cmd.op == OP_T_CHK) ? (x2_reg == 32'd0) : (b4_reg == 32'd0);
    assign status.div_busy = div_busy_reg;

    assign div_load = cmd.exec && !status.zero &&
                      (cmd.op == OP_T_CHK || cmd.op == OP_P_CHK);
    assign div_sgn  = (cmd.op == OP_T_CHK);

    always_comb
    begin
        if (div_sgn)
        begin
            div_num = {mc_s[20:0], 11'd0};
            div_dvs = x2_reg;
        end
        else
        begin
            div_num = (p_reg < K_SIGN) ? {p_reg[30:0], 1'b0} : p_reg;
            div_dvs = b4_reg;
        end
    end

    assign trial = {div_rem_reg, div_quo_reg[31]};
    assign diff  = {1'b0, trial} - {2'b00, div_den_reg};
    assign div_q = div_neg_reg ? (32'd0 - div_quo_reg) : div_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= 5'd0;
        end
        else if (div_load)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= 5'd0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_cnt_reg == 5'd31)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            div_rem_reg <= 32'd0;
            div_quo_reg <= (div_sgn && div_num[31]) ? (32'd0 - div_num) : div_num;
            div_den_reg <= (div_sgn && div_dvs[31]) ? (32'd0 - div_dvs) : div_dvs;
            div_neg_reg <= div_sgn && (div_num[31] ^ div_dvs[31]);
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= diff[33] ? trial[31:0] : diff[31:0];
            div_quo_reg <= {div_quo_reg[30:0], ~diff[33]};
        end
    end

    // stored B5
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b5_reg <= 32'd0;
        end
        else if (cmd.exec && cmd.op == OP_T_B5)
        begin
            b5_reg <= x1_reg + div_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_action;
            raw_reg  <= in_raw;
        end
        if (cmd.exec)
        begin
            case (cmd.op)
                OP_T_DIFF: p_reg  <= raw_u - ac6_u;
                OP_T_X1:   x1_reg <= 32'(prod_s >>> 15);
                OP_T_DEN:  x2_reg <= x1_reg + md_s;
                OP_T_CHK:
                begin
                    if (status.zero)
                    begin
                        value_reg <= 32'd0;
                        err_reg   <= 1'b1;
                    end
                end
                OP_T_VAL:
                begin
                    value_reg <= 32'($signed(b5_reg + 32'd8) >>> 4);
                    err_reg   <= 1'b0;
                end
                OP_P_B6:   b6_reg <= b5_reg - K_B6_OFS;
                OP_P_SQ:   sq_reg <= 32'(prod_s >>> 12);
                OP_P_X1A:  x1_reg <= 32'(prod_s >>> 11);
                OP_P_X2A:  x2_reg <= 32'(prod_s >>> 11);
                OP_P_X3A:  x3_reg <= sum_a + sum_b;
                OP_P_B3:   b3_reg <= 32'($signed(sum_a + sum_b) >>> 2);
                OP_P_X1B:  x1_reg <= 32'(prod_s >>> 13);
                OP_P_X2B:  x2_reg <= 32'(prod_s >>> 16);
                OP_P_X3B:  x3_reg <= 32'($signed(sum_a + sum_b) >>> 2);
                OP_P_T:    x3_reg <= x3_reg + K_B4_OFS;
                OP_P_B4:   b4_reg <= prod >> 15;
                OP_P_DIFF: p_reg  <= raw_u - b3_reg;
                OP_P_B7:
                begin
                    p_reg     <= prod;
                    pflag_reg <= (prod >= K_SIGN);
                end
                OP_P_CHK:
                begin
                    if (status.zero)
                    begin
                        value_reg <= 32'd0;
                        err_reg   <= 1'b1;
                    end
                end
                OP_P_P:    p_reg  <= pflag_reg ? {div_q[30:0], 1'b0} : div_q;
                OP_P_F1:   x1_reg <= 32'($signed(p_reg) >>> 8);
                OP_P_F2:   x1_reg <= prod;
                OP_P_F3:   x1_reg <= 32'(prod_s >>> 16);
                OP_P_F4:   x2_reg <= 32'(prod_s >>> 16);
                OP_P_F5:   x3_reg <= 32'($signed(sum_a + sum_b) >>> 4);
                OP_P_VAL:
                begin
                    value_reg <= p_reg + x3_reg;
                    err_reg   <= 1'b0;
                end
                default:   x1_reg <= x1_reg;
            endcase
        end
    end

    assign res_kind  = kind_reg;
    assign res_value = value_reg;
    assign res_err   = err_reg;

endmodule

[hw/rtl/baro_sensor_compensation.sv]
// Channel   Role        Payload
// in_if     sink        action, raw_value
// out_if    source      kind, value, div_error
// apb       config      coef_ac1..coef_mc_md at 4*i
//
// One reading at a time; in_if.ready is high only while idle.
// Temperature runs 4 steps, the serial divider, then 2 steps; pressure runs 14,
// the divider, then 7. The steps that multiply share one multiplier.
// A zero divisor skips the divider and the later steps: result zero, div_error set.
// Result is held until out_if.ready; the block then returns to idle before the next accept.
// Reset clears B5 to zero.
module baro_sensor_compensation (
    input  logic                       clk,
    input  logic                       rst_n,
    bsc_in_if.sink                     in_if,
    bsc_out_if.source                  out_if,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bsc_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import bsc_pkg::*;

    cfg_t        cfg;
    cmd_t        cmd;
    status_t     status;
    logic        res_kind;
    logic [31:0] res_value;
    logic        res_err;

    assign pready = 1'b1;

    bsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_if.valid),
        .in_action (in_if.action),
        .in_ready  (in_if.ready),
        .out_valid (out_if.valid),
        .out_ready (out_if.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .in_action (in_if.action),
        .in_raw    (in_if.raw_value),
        .status    (status),
        .res_kind  (res_kind),
        .res_value (res_value),
        .res_err   (res_err)
    );

    assign out_if.kind      = res_kind;
    assign out_if.value     = res_value;
    assign out_if.div_error = res_err;

endmodule

[hw/rtl/bsc_checker.sv]
`include "assert_macros.svh"

module bsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_value,
    input logic        out_error
);

    `BSC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_value), "stalled result changed")
    `BSC_ASSERT_IMP(a_one_item, clk, rst_n, out_valid, !in_ready, "input taken while result pending")
    `BSC_ASSERT_NXT(a_busy_after_acc, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid, "no processing after accept")
    `BSC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_error, out_value == 32'd0, "error result not zero")

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_value (out_if.value),
    .out_error (out_if.div_error)
);

[sim/baro_sensor_compensation_tb.sv]
module baro_sensor_compensation_tb;
    import bsc_pkg::*;

    typedef struct {
        logic        action;
        logic [15:0] raw;
    } reading_t;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        div_error;
    } comp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PaddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    bsc_in_if  in_bus ();
    bsc_out_if out_bus ();

    baro_sensor_compensation dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_if   (in_bus),
        .out_if  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // calibration copy and stored B5
    logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6;
    logic [31:0] cal_b1b2, cal_mcmd;
    logic [31:0] b5_reg;

    reading_t pending[$];
    comp_t    expected_results[$];
    int       errors = 0;
    int       in_gap = 0;
    int       out_gap = 0;
    int       results_seen = 0;
    int       hold_left = 0;
    bit       hold_done = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        logic [31:0] r;
        r = $signed(v) >>> s;
        return r;
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'b0, a} * {32'b0, b};
        return p[31:0];
    endfunction

    function automatic logic [31:0] sdiv32(input logic [31:0] a, input logic [31:0] b);
        longint qa, qb, q;
        qa = longint'($signed(a));
        qb = longint'($signed(b));
        q = qa / qb;
        return q[31:0];
    endfunction

    // compensates one reading, updating the stored B5 on a good temperature
    function comp_t compensate(input reading_t rd);
        comp_t r;
        logic [31:0] raw32, x1, x2, x3, den, b6, sq, b3, b4, b7, p;
        raw32 = {16'b0, rd.raw};
        r.kind = rd.action;
        r.value = '0;
        r.div_error = 1'b0;
        if (rd.action == 1'b0)
        begin
            x1 = asr(mul32(raw32 - {16'b0, cal_ac6}, {16'b0, cal_ac5}), 15);
            den = x1 + sx16(cal_mcmd[15:0]);
            if (den == 0)
                r.div_error = 1'b1;
            else
            begin
                x2 = sdiv32(mul32(sx16(cal_mcmd[31:16]), 32'd2048), den);
                b5_reg = x1 + x2;
                r.value = asr(b5_reg + 32'd8, 4);
            end
        end
        else
        begin
            b6 = b5_reg - K_B6_OFS;
            sq = asr(mul32(b6, b6), 12);
            x1 = asr(mul32(sq, sx16(cal_b1b2[15:0])), 11);
            x2 = asr(mul32(sx16(cal_ac2), b6), 11);
            x3 = x1 + x2;
            b3 = asr(mul32(sx16(cal_ac1), 32'd4) + x3 + 32'd2, 2);
            x1 = asr(mul32(sx16(cal_ac3), b6), 13);
            x2 = asr(mul32(sx16(cal_b1b2[31:16]), sq), 16);
            x3 = asr(x1 + x2 + 32'd2, 2);
            b4 = mul32({16'b0, cal_ac4}, x3 + K_B4_OFS) >> 15;
            if (b4 == 0)
                r.div_error = 1'b1;
            else
            begin
                b7 = mul32(raw32 - b3, K_B7_MUL);
                if (b7 < K_SIGN)
                    p = (b7 << 1) / b4;
                else
                    p = (b7 / b4) << 1;
                x1 = asr(p, 8);
                x1 = mul32(x1, x1);
                x1 = asr(mul32(x1, K_MG), 16);
                x2 = asr(mul32(p, K_MH), 16);
                r.value = p + asr(x1 + x2 + K_MI, 4);
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65)
            return 0;
        if (sel < 93)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // driver
    always @(posedge clk)
    begin
        reading_t rd;
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else
        begin
            if (in_bus.valid && in_bus.ready)
            begin
                rd.action = in_bus.action;
                rd.raw = in_bus.raw_value;
                expected_results.push_back(compensate(rd));
            end
            if (in_bus.valid && !in_bus.ready)
                ;
            else if (in_gap > 0)
            begin
                in_gap--;
                in_bus.valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                rd = pending.pop_front();
                in_bus.valid <= 1'b1;
                in_bus.action <= rd.action;
                in_bus.raw_value <= rd.raw;
                in_gap = pick_gap();
            end
            else
                in_bus.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        comp_t want;
        if (!rst_n)
            out_bus.ready <= 1'b0;
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transaction: kind=%0d value=%0d err=%0d",
                                 out_bus.kind, out_bus.value, out_bus.div_error);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_bus.kind !== want.kind || out_bus.value !== want.value
                        || out_bus.div_error !== want.div_error)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp kind=%0d value=%0d err=%0d, got kind=%0d value=%0d err=%0d",
                                     want.kind, $signed(want.value), want.div_error,
                                     out_bus.kind, out_bus.value, out_bus.div_error);
                    end
                end
            end
            if (hold_left > 0)
                out_bus.ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_gap--;
                out_bus.ready <= 1'b0;
            end
            else
            begin
                out_bus.ready <= 1'b1;
                if (out_bus.valid && out_bus.ready)
                    out_gap = pick_gap();
            end
        end
    end

    // long receiver hold-off once, while the sender keeps offering
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && results_seen >= 300)
            begin
                hold_left <= 700;
                hold_done <= 1'b1;
            end
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
        end
    end

    task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_AC1:  cal_ac1 = data[15:0];
            REG_AC2:  cal_ac2 = data[15:0];
            REG_AC3:  cal_ac3 = data[15:0];
            REG_AC4:  cal_ac4 = data[15:0];
            REG_AC5:  cal_ac5 = data[15:0];
            REG_AC6:  cal_ac6 = data[15:0];
            REG_B1B2: cal_b1b2 = data;
            REG_MCMD: cal_mcmd = data;
            default: ;
        endcase
    endtask

    // sampled at the falling edge, once the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (pending.size() != 0 || in_bus.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic add_reading(input logic act, input logic [15:0] raw);
        reading_t rd;
        rd.action = act;
        rd.raw = raw;
        pending.push_back(rd);
    endtask

    // mostly realistic temperature/pressure pairs, the rest unrelated readings
    task automatic add_random(input int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
            begin
                add_reading(1'b0, 16'($urandom_range(20000, 36000)));
                add_reading(1'b1, 16'($urandom_range(15000, 42000)));
                i++;
            end
            else if (sel < 60)
                add_reading(1'($urandom_range(0, 1)),
                            ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000);
            else
                add_reading(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        in_bus.valid = 1'b0;
        in_bus.action = 1'b0;
        in_bus.raw_value = '0;
        out_bus.ready = 1'b0;
        cal_ac1 = RST_AC1;
        cal_ac2 = RST_AC2;
        cal_ac3 = RST_AC3;
        cal_ac4 = RST_AC4;
        cal_ac5 = RST_AC5;
        cal_ac6 = RST_AC6;
        cal_b1b2 = RST_B1B2;
        cal_mcmd = RST_MCMD;
        b5_reg = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // pressure with B5 still zero, then extremes at reset calibration
        add_reading(1'b1, 16'd23843);
        add_reading(1'b1, 16'h0000);
        add_reading(1'b0, 16'h0000);
        add_reading(1'b0, 16'hFFFF);
        add_reading(1'b1, 16'hFFFF);
        add_reading(1'b0, RST_AC6);
        add_reading(1'b1, 16'h8000);
        add_reading(1'b0, 16'd27898);
        add_reading(1'b1, 16'd23843);
        add_reading(1'b0, 16'h5555);
        add_reading(1'b1, 16'hAAAA);
        wait_drained();
        // sender pauses until everything is back before the next burst
        add_random(350);
        wait_drained();

        // extreme calibration words
        cfg_write(REG_AC1, 32'h0000_8000);
        cfg_write(REG_AC2, 32'h0000_7FFF);
        cfg_write(REG_AC3, 32'h0000_8000);
        cfg_write(REG_AC4, 32'h0000_FFFF);
        cfg_write(REG_AC5, 32'h0000_FFFF);
        cfg_write(REG_AC6, 32'h0000_0000);
        cfg_write(REG_B1B2, 32'h7FFF_8000);
        cfg_write(REG_MCMD, 32'h8000_7FFF);
        add_reading(1'b0, 16'hFFFF);
        add_reading(1'b1, 16'h0000);
        add_reading(1'b0, 16'h0000);
        add_reading(1'b1, 16'hFFFF);
        add_random(200);
        wait_drained();

        // zero divisors: MD = 0 with raw = AC6, and AC4 = 0
        cfg_write(REG_AC6, 32'hFFFF_04D2);
        cfg_write(REG_MCMD, 32'h1234_0000);
        cfg_write(REG_AC4, 32'h0000_0000);
        add_reading(1'b0, 16'h04D2);
        add_reading(1'b1, 16'd30000);
        add_reading(1'b0, 16'd30000);
        add_reading(1'b1, 16'h0000);
        add_random(120);
        wait_drained();

        // random calibration, upper bits of narrow registers set at random
        for (int k = 0; k < 3; k++)
        begin
            cfg_write(REG_AC1, $urandom);
            cfg_write(REG_AC2, $urandom);
            cfg_write(REG_AC3, $urandom);
            cfg_write(REG_AC4, $urandom);
            cfg_write(REG_AC5, $urandom);
            cfg_write(REG_AC6, $urandom);
            cfg_write(REG_B1B2, $urandom);
            cfg_write(REG_MCMD, $urandom);
            add_random(140);
            wait_drained();
        end

        if (errors == 0)
            $display("baro_sensor_compensation test passed");
        else
            $display("baro_sensor_compensation test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("baro_sensor_compensation test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bsc_pkg.sv
hw/rtl/bsc_in_if.sv
hw/rtl/bsc_out_if.sv
hw/rtl/bsc_regs.sv
hw/rtl/bsc_ctrl.sv
hw/rtl/bsc_dp.sv
hw/rtl/baro_sensor_compensation.sv
hw/rtl/bsc_checker.sv
sim/baro_sensor_compensation_tb.sv
